// ----- sv/ltgl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ltgl_pkg: shared types and constants of the load tracking gain loop
// Payload words, controller/datapath command and status, code constants and
// the arctangent table of the angle unit.
// ----------------------------------------------------------------------------
package ltgl_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ITER_W       = 5;
   localparam int SQRT_STEPS   = 32;
   localparam int NUM_W        = 65;
   localparam int DEN_W        = 32;
   localparam int DIV_CNT_W    = 7;

   localparam logic [1:0] OP_INIT   = 2'd0;
   localparam logic [1:0] OP_ADJUST = 2'd1;
   localparam logic [1:0] OP_CHECK  = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [1:0] MODE_REAL  = 2'd0;
   localparam logic [1:0] MODE_IMAG  = 2'd1;
   localparam logic [1:0] MODE_MAG   = 2'd2;
   localparam logic [1:0] MODE_ANGLE = 2'd3;

   localparam logic [2:0] CSR_SETPOINT  = 3'd0;
   localparam logic [2:0] CSR_FULLSCALE = 3'd1;
   localparam logic [2:0] CSR_DEADBAND  = 3'd2;
   localparam logic [2:0] CSR_DAMPING   = 3'd3;
   localparam logic [2:0] CSR_MODE      = 3'd4;
   localparam logic [2:0] CSR_COMPLEX   = 3'd5;

   localparam logic [1:0] FB_DIRECT = 2'd0;
   localparam logic [1:0] FB_SQRT   = 2'd1;
   localparam logic [1:0] FB_CORDIC = 2'd2;

   localparam logic [1:0] DIV_FF    = 2'd0;
   localparam logic [1:0] DIV_RATIO = 2'd1;
   localparam logic [1:0] DIV_DAMP  = 2'd2;

   localparam logic signed [19:0] HALF_PI = 20'sd102944;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] meas_re;
      logic signed [31:0] meas_im;
   } ltgl_req_type;

   typedef struct packed {
      logic signed [31:0] gain_out;
      logic signed [31:0] feedback_value;
      logic               need_iteration;
   } ltgl_rsp_type;

   typedef struct packed {
      logic       load;
      logic       fb_direct;
      logic       sq_mul;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       fb_mag;
      logic       cordic_init;
      logic       cordic_step;
      logic       fb_angle;
      logic       band;
      logic       div_start;
      logic [1:0] div_sel;
      logic       ff_write;
      logic       gain_zero;
      logic       set_need;
      logic       cap_factor;
      logic       mul_lo;
      logic       mul_hi;
      logic       gain_mul;
      logic       rsp_load;
   } ltgl_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] fb_kind;
      logic       sp_zero;
      logic       fb_zero;
      logic       out_of_band;
      logic       div_done;
      logic       sqrt_last;
      logic       cordic_last;
   } ltgl_status_type;

   // round(atan(2^-i) * 65536); entries past the seventeenth are zero.
   function automatic logic [16:0] atan_entry(input logic [ITER_W-1:0] idx);
      logic [16:0] val;
      unique case (idx)
         5'd0:    val = 17'd51472;
         5'd1:    val = 17'd30386;
         5'd2:    val = 17'd16055;
         5'd3:    val = 17'd8150;
         5'd4:    val = 17'd4091;
         5'd5:    val = 17'd2047;
         5'd6:    val = 17'd1024;
         5'd7:    val = 17'd512;
         5'd8:    val = 17'd256;
         5'd9:    val = 17'd128;
         5'd10:   val = 17'd64;
         5'd11:   val = 17'd32;
         5'd12:   val = 17'd16;
         5'd13:   val = 17'd8;
         5'd14:   val = 17'd4;
         5'd15:   val = 17'd2;
         5'd16:   val = 17'd1;
         default: val = 17'd0;
      endcase
      return val;
   endfunction

   // Applies a sign to a magnitude and saturates to signed 32 bits.
   function automatic logic [31:0] sat_q16(input logic neg, input logic [67:0] mag);
      logic [31:0] res;
      if (neg) begin
         if (mag > 68'h0_8000_0000) res = 32'h8000_0000;
         else res = ~mag[31:0] + 32'd1;
      end else begin
         if (mag > 68'h0_7FFF_FFFF) res = 32'h7FFF_FFFF;
         else res = mag[31:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- sv/ltgl_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ltgl_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses once.
// ----------------------------------------------------------------------------
module ltgl_div
   import ltgl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);

   logic [NUM_W-1:0]     quot_ff, quot_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W+1:0]     diff;

   always_comb begin
      trial   = {rem_ff, quot_ff[NUM_W-1]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder always stays below the divisor.
         if (!diff[DEN_W+1]) rem_in = diff[DEN_W-1:0];
         else rem_in = trial[DEN_W-1:0];
         quot_in = {quot_ff[NUM_W-2:0], ~diff[DEN_W+1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

// ----- sv/ltgl_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ltgl_dpath: datapath of the load tracking gain loop
// Settings registers, feedback units (square root, angle), band test,
// divider operands, gain multiply with saturation and the result register.
// ----------------------------------------------------------------------------
module ltgl_dpath
   import ltgl_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_wr_en,
   input  wire logic [2:0]      csr_index,
   input  wire logic [31:0]     csr_wdata,
   input  wire ltgl_req_type    req_data,
   input  wire ltgl_cmd_type    cmd,
   output ltgl_status_type      status,
   output ltgl_rsp_type         rsp_data
);

   logic signed [31:0] setpoint_ff;
   logic [30:0]        full_scale_ff;
   logic [12:0]        deadband_ff;
   logic [30:0]        damping_ff;
   logic [1:0]         mode_ff;
   logic               complex_ff;

   logic [1:0]         op_ff, op_in;
   logic signed [31:0] re_ff, re_in, im_ff, im_in;
   logic [31:0]        fb_ff, fb_in;
   logic [31:0]        gain_ff, gain_in;
   logic               need_ff, need_in;
   logic [63:0]        sq_a_ff, sq_a_in, sq_b_ff, sq_b_in;
   logic [63:0]        sq_n_ff, sq_n_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic signed [34:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [19:0] cz_ff, cz_in;
   logic               czero_ff, czero_in;
   logic [46:0]        errx_ff, errx_in;
   logic [43:0]        band_ff, band_in;
   logic               rneg_ff, rneg_in;
   logic [51:0]        af_ff, af_in;
   logic               mneg_ff, mneg_in;
   logic [57:0]        pp_lo_ff, pp_lo_in, pp_hi_ff, pp_hi_in;
   ltgl_rsp_type       rsp_ff, rsp_in;

   logic [30:0]        fs_val;
   logic [31:0]        re_abs, im_abs, sp_abs, fb_abs, gain_abs, mag_sat;
   logic signed [32:0] delta;
   logic [32:0]        delta_abs;
   logic [63:0]        sq_sum;
   logic signed [34:0] re_x, im_x, dx, dy;
   logic signed [19:0] atan_s;
   logic [51:0]        q52, factor;
   logic [83:0]        prod;
   logic [NUM_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;
   logic               div_done;
   logic [NUM_W-1:0]   div_quot;

   // Settings registers; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff   <= '0;
         full_scale_ff <= 31'd65536;
         deadband_ff   <= 13'd100;
         damping_ff    <= '0;
         mode_ff       <= MODE_MAG;
         complex_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SETPOINT:  setpoint_ff   <= csr_wdata;
            CSR_FULLSCALE: full_scale_ff <= csr_wdata[30:0];
            CSR_DEADBAND:  deadband_ff   <= csr_wdata[12:0];
            CSR_DAMPING:   damping_ff    <= csr_wdata[30:0];
            CSR_MODE:      mode_ff       <= csr_wdata[1:0];
            CSR_COMPLEX:   complex_ff    <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      fs_val    = (full_scale_ff == '0) ? 31'd1 : full_scale_ff;
      re_abs    = re_ff[31] ? (~re_ff + 32'd1) : re_ff;
      im_abs    = im_ff[31] ? (~im_ff + 32'd1) : im_ff;
      sp_abs    = setpoint_ff[31] ? (~setpoint_ff + 32'd1) : setpoint_ff;
      fb_abs    = fb_ff[31] ? (~fb_ff + 32'd1) : fb_ff;
      gain_abs  = gain_ff[31] ? (~gain_ff + 32'd1) : gain_ff;
      delta     = 33'(setpoint_ff) - 33'(signed'(fb_ff));
      delta_abs = delta[32] ? (~delta + 33'd1) : delta;
      sq_sum    = sq_res_ff + sq_bit_ff;
      mag_sat   = (sq_res_ff > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : sq_res_ff[31:0];
      re_x      = 35'(re_ff);
      im_x      = 35'(im_ff);
      dx        = cy_ff >>> iter_ff;
      dy        = cx_ff >>> iter_ff;
      atan_s    = signed'({3'b000, atan_entry(iter_ff)});
      q52       = {2'b00, div_quot[49:0]};
      factor    = 52'd65536 + (rneg_ff ? (~q52 + 52'd1) : q52);
      prod      = 84'(pp_lo_ff) + {pp_hi_ff, 26'd0};
   end

   // Divider operands.
   always_comb begin
      unique case (cmd.div_sel)
         DIV_RATIO: begin
            div_num = NUM_W'({delta_abs, 16'h0000});
            div_den = fb_abs;
         end
         DIV_DAMP: begin
            div_num = {div_quot[48:0], 16'h0000};
            div_den = 32'd65536 + {1'b0, damping_ff};
         end
         default: begin
            div_num = NUM_W'({sp_abs, 16'h0000});
            div_den = {1'b0, fs_val};
         end
      endcase
   end

   ltgl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      op_in     = op_ff;
      re_in     = re_ff;
      im_in     = im_ff;
      fb_in     = fb_ff;
      gain_in   = gain_ff;
      need_in   = need_ff;
      sq_a_in   = sq_a_ff;
      sq_b_in   = sq_b_ff;
      sq_n_in   = sq_n_ff;
      sq_res_in = sq_res_ff;
      sq_bit_in = sq_bit_ff;
      iter_in   = iter_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cz_in     = cz_ff;
      czero_in  = czero_ff;
      errx_in   = errx_ff;
      band_in   = band_ff;
      rneg_in   = rneg_ff;
      af_in     = af_ff;
      mneg_in   = mneg_ff;
      pp_lo_in  = pp_lo_ff;
      pp_hi_in  = pp_hi_ff;
      rsp_in    = rsp_ff;

      if (cmd.load) begin
         op_in   = req_data.opcode;
         re_in   = req_data.meas_re;
         im_in   = req_data.meas_im;
         need_in = 1'b0;
      end
      if (cmd.fb_direct) begin
         fb_in = (complex_ff && mode_ff == MODE_IMAG) ? im_ff : re_ff;
      end
      if (cmd.sq_mul) begin
         sq_a_in = 64'(re_abs) * 64'(re_abs);
         sq_b_in = 64'(im_abs) * 64'(im_abs);
      end
      if (cmd.sqrt_init) begin
         sq_n_in   = sq_a_ff + sq_b_ff;
         sq_res_in = '0;
         sq_bit_in = 64'h4000_0000_0000_0000;
         iter_in   = '0;
      end
      if (cmd.sqrt_step) begin
         if (sq_n_ff >= sq_sum) begin
            sq_n_in   = sq_n_ff - sq_sum;
            sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_in = sq_res_ff >> 1;
         end
         sq_bit_in = sq_bit_ff >> 2;
         iter_in   = iter_ff + 1'b1;
      end
      if (cmd.fb_mag) begin
         fb_in = re_ff[31] ? (~mag_sat + 32'd1) : mag_sat;
      end
      if (cmd.cordic_init) begin
         czero_in = (re_ff == '0) && (im_ff == '0);
         iter_in  = '0;
         if (re_ff[31]) begin
            if (!im_ff[31]) begin
               cx_in = im_x;
               cy_in = -re_x;
               cz_in = HALF_PI;
            end else begin
               cx_in = -im_x;
               cy_in = re_x;
               cz_in = -HALF_PI;
            end
         end else begin
            cx_in = re_x;
            cy_in = im_x;
            cz_in = '0;
         end
      end
      if (cmd.cordic_step) begin
         if (cy_ff > 35'sd0) begin
            cx_in = cx_ff + dx;
            cy_in = cy_ff - dy;
            cz_in = cz_ff + atan_s;
         end else begin
            cx_in = cx_ff - dx;
            cy_in = cy_ff + dy;
            cz_in = cz_ff - atan_s;
         end
         iter_in = iter_ff + 1'b1;
      end
      if (cmd.fb_angle) begin
         fb_in = czero_ff ? 32'd0 : 32'(cz_ff);
      end
      if (cmd.band) begin
         errx_in = 47'(delta_abs) * 47'd10000;
         band_in = 44'(deadband_ff) * 44'(fs_val);
      end
      if (cmd.div_start && cmd.div_sel == DIV_RATIO) begin
         rneg_in = delta[32] ^ fb_ff[31];
      end
      if (cmd.ff_write) begin
         gain_in = sat_q16(setpoint_ff[31], 68'(div_quot));
      end
      if (cmd.gain_zero) begin
         gain_in = '0;
      end
      if (cmd.set_need) begin
         need_in = status.out_of_band;
      end
      if (cmd.cap_factor) begin
         af_in   = factor[51] ? (~factor + 52'd1) : factor;
         mneg_in = gain_ff[31] ^ factor[51];
      end
      if (cmd.mul_lo) begin
         pp_lo_in = 58'(gain_abs) * 58'(af_ff[25:0]);
      end
      if (cmd.mul_hi) begin
         pp_hi_in = 58'(gain_abs) * 58'(af_ff[51:26]);
      end
      if (cmd.gain_mul) begin
         gain_in = sat_q16(mneg_ff, prod[83:16]);
      end
      if (cmd.rsp_load) begin
         rsp_in.gain_out       = gain_ff;
         rsp_in.feedback_value = fb_ff;
         rsp_in.need_iteration = need_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
         need_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         gain_ff <= gain_in;
         need_ff <= need_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      re_ff     <= re_in;
      im_ff     <= im_in;
      fb_ff     <= fb_in;
      sq_a_ff   <= sq_a_in;
      sq_b_ff   <= sq_b_in;
      sq_n_ff   <= sq_n_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      czero_ff  <= czero_in;
      errx_ff   <= errx_in;
      band_ff   <= band_in;
      rneg_ff   <= rneg_in;
      af_ff     <= af_in;
      mneg_ff   <= mneg_in;
      pp_lo_ff  <= pp_lo_in;
      pp_hi_ff  <= pp_hi_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      status.op = op_ff;
      if (!complex_ff || mode_ff == MODE_REAL || mode_ff == MODE_IMAG)
         status.fb_kind = FB_DIRECT;
      else if (mode_ff == MODE_MAG)
         status.fb_kind = FB_SQRT;
      else
         status.fb_kind = FB_CORDIC;
      status.sp_zero     = (setpoint_ff == '0);
      status.fb_zero     = (fb_ff == '0);
      status.out_of_band = errx_ff > {3'b000, band_ff};
      status.div_done    = div_done;
      status.sqrt_last   = (iter_ff == ITER_W'(SQRT_STEPS - 1));
      status.cordic_last = (iter_ff == ITER_W'(CORDIC_STEPS - 1));
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ----- sv/ltgl_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ltgl_ctrl: sequencer of the load tracking gain loop
// Takes one word at a time, steps the datapath through feedback, band test,
// divisions and multiply, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ltgl_ctrl
   import ltgl_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire ltgl_status_type status,
   output ltgl_cmd_type         cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_FB      = 4'd1;
   localparam logic [3:0] S_SQ_INIT = 4'd2;
   localparam logic [3:0] S_SQRT    = 4'd3;
   localparam logic [3:0] S_SQ_FIN  = 4'd4;
   localparam logic [3:0] S_CORDIC  = 4'd5;
   localparam logic [3:0] S_CO_FIN  = 4'd6;
   localparam logic [3:0] S_BAND    = 4'd7;
   localparam logic [3:0] S_DECIDE  = 4'd8;
   localparam logic [3:0] S_DIV_FF  = 4'd9;
   localparam logic [3:0] S_DIV_R   = 4'd10;
   localparam logic [3:0] S_DIV_C   = 4'd11;
   localparam logic [3:0] S_MUL_LO  = 4'd12;
   localparam logic [3:0] S_MUL_HI  = 4'd13;
   localparam logic [3:0] S_MUL_SUM = 4'd14;
   localparam logic [3:0] S_OUT     = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_FB;
            end
         end
         S_FB: begin
            priority if (status.fb_kind == FB_SQRT) begin
               cmd.sq_mul = 1'b1;
               state_in   = S_SQ_INIT;
            end else if (status.fb_kind == FB_CORDIC) begin
               cmd.cordic_init = 1'b1;
               state_in        = S_CORDIC;
            end else begin
               cmd.fb_direct = 1'b1;
               state_in      = S_BAND;
            end
         end
         S_SQ_INIT: begin
            cmd.sqrt_init = 1'b1;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (status.sqrt_last) state_in = S_SQ_FIN;
         end
         S_SQ_FIN: begin
            cmd.fb_mag = 1'b1;
            state_in   = S_BAND;
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (status.cordic_last) state_in = S_CO_FIN;
         end
         S_CO_FIN: begin
            cmd.fb_angle = 1'b1;
            state_in     = S_BAND;
         end
         S_BAND: begin
            cmd.band = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            priority if (status.op == OP_INIT) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_FF;
               state_in      = S_DIV_FF;
            end else if (status.op == OP_ADJUST) begin
               priority if (status.sp_zero) begin
                  cmd.gain_zero = 1'b1;
                  state_in      = S_OUT;
               end else if (status.fb_zero) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_FF;
                  state_in      = S_DIV_FF;
               end else if (status.out_of_band) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_RATIO;
                  state_in      = S_DIV_R;
               end else begin
                  state_in = S_OUT;
               end
            end else if (status.op == OP_CHECK) begin
               cmd.set_need = 1'b1;
               state_in     = S_OUT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV_FF: begin
            if (status.div_done) begin
               cmd.ff_write = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_DIV_R: begin
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_DAMP;
               state_in      = S_DIV_C;
            end
         end
         S_DIV_C: begin
            if (status.div_done) begin
               cmd.cap_factor = 1'b1;
               state_in       = S_MUL_LO;
            end
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_MUL_SUM;
         end
         S_MUL_SUM: begin
            cmd.gain_mul = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- sv/load_tracking_gain_loop_core.sv -----
`default_nettype none
// Words are taken one at a time: an init uses the shared restoring divider
// once, an adjust up to twice, and a magnitude or angle feedback runs the
// 32-step square root or the angle unit ahead of the band test.
// Reset is synchronous and active high: gain clears, settings take their
// defaults, no result is pending.
// ----------------------------------------------------------------------------
// load_tracking_gain_loop_core: load tracking gain loop in signed Q16.16
// A sequencer drives a datapath that derives the feedback from the
// measurement, tests it against the deadband and updates the output gain.
// ----------------------------------------------------------------------------
module load_tracking_gain_loop_core
   import ltgl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel: one word carries an opcode and a measurement.
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire ltgl_req_type req_data,
   // Response channel: one word per request.
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output ltgl_rsp_type      rsp_data,
   // Settings write port.
   input  wire logic         csr_wr_en,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);

   // The sequencer and the datapath talk only through these two bundles.
   ltgl_cmd_type    cmd;
   ltgl_status_type status;

   // The sequencer holds the request side off while a word is in work, and
   // owns the valid flag of the response register, so a finished word may wait
   // there while the next request is already taken.
   ltgl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the settings, the gain, the square root and angle
   // units, the shared divider and the split gain multiplier.
   ltgl_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // A word taken in must close the request side on the next cycle.
   a_accept_blocks : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side open while a word is in work");

   // A response only appears after a word has been worked on.
   a_rsp_after_work : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response raised without a word in work");
`endif

endmodule
`default_nettype wire

// ----- test/load_tracking_gain_loop_core_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// load_tracking_gain_loop_core_checker: response checker of the gain loop
// Watches the request, response and settings ports. It keeps its own copy of
// the settings and the gain, predicts every response and compares it field by
// field.
// ----------------------------------------------------------------------------
module load_tracking_gain_loop_core_checker
   import ltgl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire ltgl_req_type req_data,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire ltgl_rsp_type rsp_data,
   input  wire logic         csr_wr_en,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_wdata,
   output int                fail_count,
   output int                pending_count
);

   logic signed [31:0] sp_q;
   logic [30:0]        fs_q;
   logic [12:0]        db_q;
   logic [30:0]        damp_q;
   logic [1:0]         mode_q;
   logic               cplx_q;
   logic signed [63:0] gain_q;

   ltgl_rsp_type gain_words[$];

   assign pending_count = gain_words.size();

   function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic signed [63:0] fs_val();
      return (fs_q == 0) ? 64'sd1 : $signed({33'd0, fs_q});
   endfunction

   function automatic logic signed [63:0] feed_fwd();
      logic signed [63:0] num;
      num = 64'(sp_q) * 64'sd65536;
      return sat32(num / fs_val());
   endfunction

   function automatic logic band_miss(input logic signed [63:0] fb);
      logic signed [63:0] d;
      logic [63:0] err;
      d = 64'(sp_q) - fb;
      err = (d < 0) ? -d : d;
      return err * 64'd10000 > 64'(db_q) * 64'(fs_val());
   endfunction

   function automatic logic signed [63:0] arctan_of(input logic signed [63:0] xi,
                                                     input logic signed [63:0] yi);
      logic signed [63:0] x, y, z, t, dx, dy, ang;
      x = xi;
      y = yi;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 64'sd102944;
         end else begin
            x = -y; y = t; z = -64'sd102944;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         ang = i < 17 ? $signed({47'd0, atan_entry(5'(i))}) : 64'sd0;
         if (y > 0) begin
            x += dx; y -= dy; z += ang;
         end else begin
            x -= dx; y += dy; z -= ang;
         end
      end
      return z;
   endfunction

   function automatic logic signed [63:0] feedback_of(input ltgl_req_type w);
      logic signed [63:0] re, im;
      logic [63:0] sq, rt, bt;
      re = 64'(w.meas_re);
      im = 64'(w.meas_im);
      if (!cplx_q) return re;
      case (mode_q)
         MODE_REAL: return re;
         MODE_IMAG: return im;
         MODE_MAG: begin
            sq = 64'(re * re) + 64'(im * im);
            rt = 0;
            bt = 64'd1 << 62;
            while (bt > sq) bt >>= 2;
            while (bt != 0) begin
               if (sq >= rt + bt) begin
                  sq -= rt + bt; rt = (rt >> 1) + bt;
               end else begin
                  rt >>= 1;
               end
               bt >>= 2;
            end
            if (rt > 64'd2147483647) rt = 64'd2147483647;
            return re < 0 ? -$signed(rt) : $signed(rt);
         end
         default: return arctan_of(re, im);
      endcase
   endfunction

   task automatic adjust_gain(input logic signed [63:0] fb);
      logic signed [63:0] r, den, q, rm, c, fac;
      logic [63:0] ag, af, p;
      logic neg;
      if (sp_q == 0) begin
         gain_q = 0;
         return;
      end
      if (fb == 0) begin
         gain_q = feed_fwd();
         return;
      end
      if (!band_miss(fb)) return;
      r = ((64'(sp_q) - fb) * 64'sd65536) / fb;
      den = 64'sd65536 + $signed({33'd0, damp_q});
      q = r / den;
      rm = r % den;
      c = q * 64'sd65536 + (rm * 64'sd65536) / den;
      fac = 64'sd65536 + c;
      ag = gain_q < 0 ? -gain_q : gain_q;
      af = fac < 0 ? -fac : fac;
      neg = (gain_q < 0) != (fac < 0);
      if (ag != 0 && af > (64'd1 << 62) / ag) begin
         gain_q = neg ? -64'sd2147483648 : 64'sd2147483647;
         return;
      end
      p = (ag * af) >> 16;
      gain_q = sat32(neg ? -$signed(p) : $signed(p));
   endtask

   always @(posedge clock) begin
      logic signed [63:0] fb;
      ltgl_rsp_type exp_w, got_w;
      int errs;
      errs = 0;
      if (reset) begin
         sp_q   <= '0;
         fs_q   <= 31'd65536;
         db_q   <= 13'd100;
         damp_q <= '0;
         mode_q <= MODE_MAG;
         cplx_q <= 1'b0;
         gain_q  = 0;
         gain_words.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SETPOINT:  sp_q   <= csr_wdata;
               CSR_FULLSCALE: fs_q   <= csr_wdata[30:0];
               CSR_DEADBAND:  db_q   <= csr_wdata[12:0];
               CSR_DAMPING:   damp_q <= csr_wdata[30:0];
               CSR_MODE:      mode_q <= csr_wdata[1:0];
               CSR_COMPLEX:   cplx_q <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            fb = feedback_of(req_data);
            exp_w.need_iteration = 1'b0;
            case (req_data.opcode)
               OP_INIT:   gain_q = feed_fwd();
               OP_ADJUST: adjust_gain(fb);
               OP_CHECK:  exp_w.need_iteration = band_miss(fb);
               default: ;
            endcase
            exp_w.gain_out = gain_q[31:0];
            exp_w.feedback_value = fb[31:0];
            gain_words.push_back(exp_w);
         end
         if (rsp_valid && !rsp_stall) begin
            got_w = rsp_data;
            if (gain_words.size() == 0) begin
               $error("response word with none expected: %p", got_w);
               errs++;
            end else begin
               exp_w = gain_words.pop_front();
               if (got_w.gain_out !== exp_w.gain_out) begin
                  $error("gain_out: expected %0d, got %0d", exp_w.gain_out, got_w.gain_out);
                  errs++;
               end
               if (got_w.feedback_value !== exp_w.feedback_value) begin
                  $error("feedback_value: expected %0d, got %0d",
                         exp_w.feedback_value, got_w.feedback_value);
                  errs++;
               end
               if (got_w.need_iteration !== exp_w.need_iteration) begin
                  $error("need_iteration: expected %0d, got %0d",
                         exp_w.need_iteration, got_w.need_iteration);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

// ----- test/load_tracking_gain_loop_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// load_tracking_gain_loop_core_tb: testbench of the load tracking gain loop
// Drives directed and random request words through several phases of
// settings, with random gaps on both channels, and leaves all checking to the
// checker instance. Prints the verdict at the end.
// ----------------------------------------------------------------------------
module load_tracking_gain_loop_core_tb;
   import ltgl_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   ltgl_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   ltgl_rsp_type rsp_data;
   logic         csr_wr_en;
   logic [2:0]   csr_index;
   logic [31:0]  csr_wdata;
   int           fail_count;
   int           pending_count;
   bit           rsp_hold_on;

   load_tracking_gain_loop_core DUT (.*);

   load_tracking_gain_loop_core_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A hard ceiling on the run time; a hung block lands here.
   initial begin
      #30ms;
      $display("** load_tracking_gain_loop_core: FAILED **");
      $finish;
   end

   // The response side stalls at random for each word, and in some stretches
   // it never stalls at all.
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         n = rsp_hold_on ? $urandom_range(0, 18) : 0;
         rsp_stall = n != 0;
         repeat (n) @(negedge clock);
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Sends one word, after a random gap if gaps is set; valid drops only once it is taken.
   task automatic send_word(input logic [1:0] op, input logic [31:0] re,
                            input logic [31:0] im, input bit gaps);
      int n;
      n = gaps ? $urandom_range(0, 18) : 0;
      repeat (n) @(negedge clock);
      req_valid = 1'b1;
      req_data.opcode = op;
      req_data.meas_re = re;
      req_data.meas_im = im;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
      req_data.opcode = 2'($urandom);
      req_data.meas_re = $urandom;
      req_data.meas_im = $urandom;
   endtask

   // Waits for every expected word, then lets the block settle.
   task automatic drain();
      int guard;
      guard = 0;
      while (pending_count != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (300) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_meas();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(int'($urandom_range(0, 20000)) - 10000) <<< 8;
         3: return 32'(int'($urandom_range(0, 200)) - 100) <<< 16;
         4: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] sp;
      logic [1:0]  op;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_SETPOINT;
      csr_wdata = '0;
      rsp_hold_on = 1'b1;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Directed words on the reset settings: zero setpoint, then a usable one.
      send_word(OP_ADJUST, 32'd65536, 32'd0, 1'b0);
      send_word(OP_NOP, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      drain();
      write_reg(CSR_SETPOINT, 32'd131072);
      send_word(OP_INIT, 32'd0, 32'd0, 1'b0);
      send_word(OP_ADJUST, 32'd0, 32'd0, 1'b0);
      send_word(OP_ADJUST, 32'd65536, 32'd0, 1'b0);
      send_word(OP_ADJUST, 32'h8000_0000, 32'd0, 1'b0);
      send_word(OP_ADJUST, 32'h7FFF_FFFF, 32'd0, 1'b0);
      send_word(OP_CHECK, 32'd131072, 32'd0, 1'b0);
      send_word(OP_CHECK, 32'd0, 32'd0, 1'b0);
      send_word(OP_NOP, 32'd5, 32'd0, 1'b0);
      drain();
      // Complex source in every mode, with the zero vector and the corners.
      write_reg(CSR_COMPLEX, 32'd1);
      for (int m = 0; m < 4; m++) begin
         write_reg(CSR_MODE, 32'(m));
         send_word(OP_CHECK, 32'h8000_0000, 32'h8000_0000, 1'b0);
         send_word(OP_ADJUST, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
         send_word(OP_CHECK, 32'd0, 32'd0, 1'b0);
         send_word(OP_ADJUST, 32'hFFFF_0000, 32'd65536, 1'b0);
         drain();
      end
      // Zero full scale and a zero deadband, used as written.
      write_reg(CSR_FULLSCALE, 32'd0);
      write_reg(CSR_DEADBAND, 32'd0);
      write_reg(CSR_DAMPING, 32'h7FFF_FFFF);
      send_word(OP_INIT, 32'd1, 32'd1, 1'b0);
      send_word(OP_CHECK, 32'd131071, 32'd0, 1'b0);
      send_word(OP_ADJUST, 32'd1000, 32'd77, 1'b0);
      drain();

      // Random phases: settings change only once the block has gone idle.
      for (int ph = 0; ph < 24; ph++) begin
         case (ph % 4)
            0: sp = 32'(int'($urandom_range(0, 400)) - 200) <<< 14;
            1: sp = $urandom;
            2: sp = ph % 8 == 2 ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: sp = 32'd65536;
         endcase
         write_reg(CSR_SETPOINT, sp);
         write_reg(CSR_FULLSCALE, ph % 5 == 0 ? 32'h7FFF_FFFF :
                   ph % 5 == 1 ? 32'd1 : 32'($urandom_range(1, 1 << 22)));
         write_reg(CSR_DEADBAND, ph % 3 == 0 ? 32'd100 : ph % 3 == 1 ? 32'd5000 :
                   ($urandom & 32'h1FFF));
         write_reg(CSR_DAMPING, ph % 4 == 0 ? 32'd0 : ph % 4 == 1 ? 32'h7FFF_FFFF :
                   32'($urandom_range(0, 1 << 18)));
         write_reg(CSR_MODE, 32'(ph % 4));
         write_reg(CSR_COMPLEX, 32'((ph / 4) % 2));
         rsp_hold_on = ph % 6 != 5;
         for (int k = 0; k < 50; k++) begin
            op = k == 0 ? OP_INIT : 2'($urandom_range(0, 12) < 6 ? 1 :
                                      $urandom_range(0, 3));
            send_word(op, pick_meas(), pick_meas(), ph % 6 != 4);
         end
         drain();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("** load_tracking_gain_loop_core: PASSED **");
      end else begin
         $display("** load_tracking_gain_loop_core: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/ltgl_pkg.sv
sv/ltgl_div.sv
sv/ltgl_dpath.sv
sv/ltgl_ctrl.sv
sv/load_tracking_gain_loop_core.sv
test/load_tracking_gain_loop_core_checker.sv
test/load_tracking_gain_loop_core_tb.sv
